[sv/usm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usm_pkg
// Shared types, constants and helpers for the 3x3 unsharp mask stream.
// ----------------------------------------------------------------------------
package usm_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int PIXEL_BITS   = 8;
  localparam int HEIGHT_LIMIT = 1024;

  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 9;
  localparam int HEIGHT_BITS = 11;
  localparam int COUNT_BITS  = 19;
  localparam int CFG_BITS    = 11;
  localparam int SUM_BITS    = PIXEL_BITS + 4;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_CAP   = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_CAP  = HEIGHT_BITS'(HEIGHT_LIMIT);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST   = WIDTH_BITS'(64);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST  = HEIGHT_BITS'(64);

  // register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // request modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // x/3 as (x * 2731) >> 13, exact for x below 8192
  localparam int RECIP3_BITS  = 12;
  localparam int RECIP3_SHIFT = 13;
  localparam logic [RECIP3_BITS-1:0] RECIP3 = RECIP3_BITS'(2731);

  typedef enum logic [1:0] {
    DIV_BY_2,
    DIV_BY_3,
    DIV_BY_4
  } div_kind_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic sum;
    logic div_col;
    logic div_row;
    logic commit;
  } usm_cmd_t;

  typedef struct packed {
    logic have;
    logic out_blocked;
  } usm_status_t;

  // weight sum of a 1-2-1 tap set with the outer taps possibly dropped
  function automatic div_kind_t div_kind(input logic drop_a, input logic drop_b);
    div_kind_t k;
    if (!drop_a && !drop_b) begin
      k = DIV_BY_4;
    end else if (drop_a && drop_b) begin
      k = DIV_BY_2;
    end else begin
      k = DIV_BY_3;
    end
    return k;
  endfunction

  function automatic logic [SUM_BITS-1:0] div_small(input logic [SUM_BITS-1:0] x,
                                                    input div_kind_t k);
    logic [SUM_BITS+RECIP3_BITS-1:0] prod;
    logic [SUM_BITS-1:0] q;
    prod = {{RECIP3_BITS{1'b0}}, x} * {{SUM_BITS{1'b0}}, RECIP3};
    case (k)
      DIV_BY_2: q = x >> 1;
      DIV_BY_4: q = x >> 2;
      DIV_BY_3: q = SUM_BITS'(prod[SUM_BITS+RECIP3_BITS-1:RECIP3_SHIFT]);
      default:  q = x;
    endcase
    return q;
  endfunction

endpackage

[sv/unsharp_mask_3x3_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsharp_mask_3x3_stream
// 3x3 binomial unsharp mask over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): mode selects a pixel request or a
// flush tick; pixel_in carries the pixel. Output channel (out_valid /
// out_stall): pixel_out is the sharpened pixel, last_of_frame marks the
// final pixel of the frame. Results trail the input by one row plus one
// pixel; after the frame, image_width+1 flush ticks drain the rest.
// Each request passes through a read of both line buffer banks, a window
// shift, a weighted sum, two passes through the shared divide-by-2/3/4 unit
// and a commit. The commit loads the result, if any, into the output register,
// and the next request can be taken the cycle after the commit.
// The output register holds a result while out_stall is high; a new
// request is still taken, and waits at its commit only if it has a result
// and the register is still full.
// Reset clears the counters and window and sets both sizes to 64. A write
// on the configuration port restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
module unsharp_mask_3x3_stream
  import usm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] pixel_out,
  output logic                  last_of_frame
);

  usm_cmd_t    cmd;
  usm_status_t status;

  usm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  usm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .pixel_in      (pixel_in),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  a_commit_releases: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !in_stall)
    else $error("input not released after commit");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.sum, cmd.div_col, cmd.div_row, cmd.commit}))
    else $error("more than one sequencer step active");

endmodule

[sv/usm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module usm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/usm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usm_ctrl
// Sequencer: steps one request through read, window shift, weighted sum,
// two divide passes and the final commit.
// ----------------------------------------------------------------------------
module usm_ctrl
  import usm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  usm_status_t status,
  output usm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    LOAD,
    SUM,
    DIV_COL,
    DIV_ROW,
    FINISH
  } state_t;

  state_t state;
  logic   finish_ok;

  assign finish_ok = !(status.have && status.out_blocked);

  always_comb begin
    cmd         = '0;
    cmd.accept  = in_valid && !in_stall;
    cmd.load    = (state == LOAD);
    cmd.sum     = (state == SUM);
    cmd.div_col = (state == DIV_COL);
    cmd.div_row = (state == DIV_ROW);
    cmd.commit  = (state == FINISH) && finish_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && !in_stall) begin
            state    <= LOAD;
            in_stall <= 1'b1;
          end
        end
        LOAD:    state <= SUM;
        SUM:     state <= DIV_COL;
        DIV_COL: state <= DIV_ROW;
        DIV_ROW: state <= FINISH;
        FINISH: begin
          if (finish_ok) begin
            state    <= IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

[sv/usm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usm_datapath
// Line buffers, 3x3 window, frame counters, border-aware blur with a shared
// small divider, sharpening and the output register.
// ----------------------------------------------------------------------------
module usm_datapath
  import usm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  mode,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  input  usm_cmd_t              cmd,
  output usm_status_t           status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] pixel_out,
  output logic                  last_of_frame
);

  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [WIDTH_BITS-1:0]  eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic [WIDTH_BITS+HEIGHT_BITS-1:0] total_prod;
  logic [COUNT_BITS-1:0]  frame_total;

  logic [COL_BITS-1:0]    column_count;
  logic [HEIGHT_BITS-1:0] row_count;
  logic [COUNT_BITS-1:0]  emitted_count;

  logic [PIXEL_BITS-1:0]  win [3][3];
  logic [PIXEL_BITS-1:0]  pix_v;
  logic [PIXEL_BITS-1:0]  rd_bank [2];
  logic [PIXEL_BITS-1:0]  top, mid;

  logic                   have;
  logic                   drop_l, drop_r, drop_t, drop_b;
  logic [SUM_BITS-1:0]    div_acc;
  logic [SUM_BITS-1:0]    div_out;
  div_kind_t              kind;

  logic                   at_col0;
  logic [COL_BITS-1:0]    x_pos;
  logic [HEIGHT_BITS-1:0] y_pos;
  logic [WIDTH_BITS-1:0]  x_ext;

  logic [PIXEL_BITS+1:0]  col_sum [3];
  logic [SUM_BITS-1:0]    win_sum;

  logic [COUNT_BITS-1:0]  emitted_next;
  logic                   frame_done;
  logic [WIDTH_BITS-1:0]  col_inc;

  logic [PIXEL_BITS+1:0]  blur3;
  logic signed [SUM_BITS-1:0] sharp;
  logic [PIXEL_BITS-1:0]  sharp_clamped;

  // effective frame size
  always_comb begin
    eff_w = image_width;
    if (image_width == '0) begin
      eff_w = WIDTH_BITS'(1);
    end else if (image_width > WIDTH_CAP) begin
      eff_w = WIDTH_CAP;
    end
    eff_h = image_height;
    if (image_height == '0) begin
      eff_h = HEIGHT_BITS'(1);
    end else if (image_height > HEIGHT_CAP) begin
      eff_h = HEIGHT_CAP;
    end
  end

  assign total_prod = eff_w * eff_h;

  // line buffers: one bank per row parity
  for (genvar b = 0; b < 2; b++) begin : g_bank
    usm_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (cmd.load && (row_count[0] == 1'(b))),
      .waddr (column_count),
      .wdata (pix_v),
      .re    (cmd.accept),
      .raddr (column_count),
      .rdata (rd_bank[b])
    );
  end

  assign top = row_count[0] ? rd_bank[1] : rd_bank[0];
  assign mid = row_count[0] ? rd_bank[0] : rd_bank[1];

  // position of the pixel finished by this request
  always_comb begin
    at_col0 = (column_count == '0);
    x_pos   = at_col0 ? COL_BITS'(eff_w - 1'b1) : column_count - 1'b1;
    y_pos   = at_col0 ? row_count - HEIGHT_BITS'(2) : row_count - 1'b1;
    x_ext   = WIDTH_BITS'(x_pos);
  end

  // weighted window sum
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sum[c] = (drop_t ? '0 : {2'b00, win[c][0]})
                 + {1'b0, win[c][1], 1'b0}
                 + (drop_b ? '0 : {2'b00, win[c][2]});
    end
    win_sum = (drop_l ? '0 : {2'b00, col_sum[0]})
            + {1'b0, col_sum[1], 1'b0}
            + (drop_r ? '0 : {2'b00, col_sum[2]});
  end

  assign kind    = cmd.div_col ? div_kind(drop_l, drop_r) : div_kind(drop_t, drop_b);
  assign div_out = div_small(div_acc, kind);

  // 4*centre - 3*blur, clamped
  always_comb begin
    blur3 = {1'b0, div_acc[PIXEL_BITS-1:0], 1'b0} + {2'b00, div_acc[PIXEL_BITS-1:0]};
    sharp = $signed({2'b00, win[1][1], 2'b00}) - $signed({2'b00, blur3});
    if (sharp < 0) begin
      sharp_clamped = '0;
    end else if (sharp > $signed(SUM_BITS'(255))) begin
      sharp_clamped = '1;
    end else begin
      sharp_clamped = sharp[PIXEL_BITS-1:0];
    end
  end

  assign emitted_next = emitted_count + 1'b1;
  assign frame_done   = have && (emitted_next >= frame_total);
  assign col_inc      = WIDTH_BITS'(column_count) + 1'b1;

  assign status.have        = have;
  assign status.out_blocked = out_valid && out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RST;
      image_height  <= HEIGHT_RST;
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
      have          <= 1'b0;
      out_valid     <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_BITS-1:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_BITS-1:0];
          default: ;
        endcase
        column_count  <= '0;
        row_count     <= '0;
        emitted_count <= '0;
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) begin
            win[c][r] <= '0;
          end
        end
      end else begin
        if (cmd.load) begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2][0] <= top;
          win[2][1] <= mid;
          win[2][2] <= pix_v;
          have <= at_col0 ? (row_count >= HEIGHT_BITS'(2)) : (row_count != '0);
        end
        if (cmd.commit) begin
          if (frame_done) begin
            column_count  <= '0;
            row_count     <= '0;
            emitted_count <= '0;
            for (int c = 0; c < 3; c++) begin
              for (int r = 0; r < 3; r++) begin
                win[c][r] <= '0;
              end
            end
          end else begin
            if (have) begin
              emitted_count <= emitted_next;
            end
            if (col_inc >= eff_w) begin
              column_count <= '0;
              row_count    <= row_count + 1'b1;
            end else begin
              column_count <= column_count + 1'b1;
            end
          end
        end
      end
      if (cmd.commit && have) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    frame_total <= total_prod[COUNT_BITS-1:0];
    if (cmd.accept) begin
      pix_v <= ((mode == MODE_PIXEL) && (row_count < eff_h)) ? pixel_in : '0;
    end
    if (cmd.load) begin
      drop_l <= (x_pos == '0);
      drop_r <= (x_ext + 1'b1) >= eff_w;
      drop_t <= (y_pos == '0);
      drop_b <= ({1'b0, y_pos} + 1'b1) >= {1'b0, eff_h};
    end
    if (cmd.sum) begin
      div_acc <= win_sum;
    end
    if (cmd.div_col || cmd.div_row) begin
      div_acc <= div_out;
    end
    if (cmd.commit && have) begin
      pixel_out     <= sharp_clamped;
      last_of_frame <= frame_done;
    end
  end

endmodule
